FILE: sv/lse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg: shared types and codes of the LIFO stack engine
// Operation codes, status codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_DUMP = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
    localparam logic [OP_W-1:0] OP_POP  = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage : lse_pkg
`default_nettype wire

FILE: sv/lse_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_front: input acceptance and classification
// Takes input words, drops unused operation codes and forms queue commands.
// ----------------------------------------------------------------------------
module lse_front
    import lse_pkg::*;
(
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [DATA_W-1:0] push_value,
    input  wire logic                     q_full,
    output logic                          q_write,
    output cmd_t                          q_cmd
);

    logic op_known;

    always_comb
    begin
        op_known = 1'b0;
        case (operation)
            OP_PUSH, OP_DUMP, OP_PEEK, OP_POP, OP_SWAP: op_known = 1'b1;
            default:                                    op_known = 1'b0;
        endcase
    end

    // Hold off the source only while the queue has no room.
    assign in_stall     = q_full;
    // Drop unused codes here: they never reach the back end.
    assign q_write      = in_valid && !q_full && op_known;
    assign q_cmd.op     = operation;
    // Clear the value for everything but push so the queue never carries junk.
    assign q_cmd.value  = (operation == OP_PUSH) ? push_value : '0;

endmodule : lse_front
`default_nettype wire

FILE: sv/lse_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_cmd_queue: short command queue
// Small circular buffer that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lse_cmd_queue
    import lse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output logic      full,
    input  wire logic rd_en,
    output logic      not_empty,
    output cmd_t      rd_cmd
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == QCW'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign rd_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule : lse_cmd_queue
`default_nettype wire

FILE: sv/lse_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_back: stack execution engine
// Holds the top entry in a register and the rest in a memory; runs commands.
// ----------------------------------------------------------------------------
module lse_back
    import lse_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    input  wire cmd_t                     cmd,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      out_value,
    output logic [STATUS_W-1:0]           status,
    output logic                          last
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SWAP = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic [AW-1:0]            ptr_reg, ptr_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic                     last_reg, last_next;

    logic signed [DATA_W-1:0] mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     wr_en;

    logic                     out_free;
    logic [CW-1:0]            cnt_m1;
    logic [CW-1:0]            cnt_m2;

    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_m1   = cnt_reg - CW'(1);
    assign cnt_m2   = cnt_reg - CW'(2);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        ptr_next       = ptr_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cnt_m2[AW-1:0];
        wr_data        = top_reg;
        rd_addr        = cnt_m2[AW-1:0];
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            if (cnt_reg == CW'(STACK_DEPTH))
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = '0;
                                status_next    = ST_FULL;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                // Spill the old top into the memory.
                                wr_en    = (cnt_reg != '0);
                                wr_addr  = cnt_m1[AW-1:0];
                                top_next = cmd.value;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_DUMP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = top_reg;
                                status_next    = ST_OK;
                                last_next      = (cnt_reg == CW'(1));
                                if (cnt_reg != CW'(1))
                                begin
                                    ptr_next   = cnt_m2[AW-1:0];
                                    state_next = S_DUMP;
                                end
                            end
                        end
                        OP_PEEK:
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = (cnt_reg == '0) ? '0 : top_reg;
                            status_next    = (cnt_reg == '0) ? ST_EMPTY : ST_OK;
                            last_next      = 1'b1;
                        end
                        OP_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = '0;
                                status_next    = ST_EMPTY;
                                last_next      = 1'b1;
                            end
                            else if (cnt_reg == CW'(1))
                            begin
                                cnt_next = '0;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        OP_SWAP:
                        begin
                            if (cnt_reg < CW'(2))
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = '0;
                                status_next    = ST_SHORT;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SWAP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // Refill the top from the entry just below it.
                top_next   = rdata_reg;
                cnt_next   = cnt_m1;
                state_next = S_IDLE;
            end
            S_SWAP:
            begin
                wr_en      = 1'b1;
                wr_addr    = cnt_m2[AW-1:0];
                wr_data    = top_reg;
                top_next   = rdata_reg;
                state_next = S_IDLE;
            end
            S_DUMP:
            begin
                rd_addr = ptr_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rdata_reg;
                    status_next    = ST_OK;
                    last_next      = (ptr_reg == '0);
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - AW'(1);
                        rd_addr  = ptr_reg - AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        ptr_reg       <= ptr_next;
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("entry count above stack depth");

    a_busy_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cnt_reg >= CW'(2)))
        else $error("multi-cycle operation with fewer than two entries");

    a_pop_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |=> (cnt_reg == $past(cnt_m1)))
        else $error("pop did not remove exactly one entry");

    a_dump_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> (cnt_reg == $past(cnt_reg)))
        else $error("entry count changed during dump");

endmodule : lse_back
`default_nettype wire

FILE: sv/lifo_stack_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_stack_engine_top: bounded LIFO stack of signed 32-bit words with swap
// Front end classifies operations, a short queue buffers them, and the back
// end executes them against the stack and drives the result channel.
// ----------------------------------------------------------------------------
// Usage: each input word carries one operation (push, dump, peek, pop, swap).
// The front end takes one word per cycle while the command queue has room and
// drops unused operation codes on the spot. The back end keeps the top entry
// in a register and the rest in a single-port-write memory with a registered
// read. Pop and swap on two or more entries go on to the S_POP or S_SWAP
// state, since the entry below the top must first be read; push, peek, every
// error and a pop of a lone entry finish in the idle state. Dump emits one
// result word per entry held, top first, and none on an empty stack. Each
// result word waits in an output register; the back end moves on once that
// register is free or being taken. No clearing pass follows reset: the entry
// count starts at zero and only written entries are ever read.
// ----------------------------------------------------------------------------
module lifo_stack_engine_top
    import lse_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [DATA_W-1:0] push_value,
    // result channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      out_value,
    output logic [STATUS_W-1:0]           status,
    output logic                          last
);

    // Front-to-queue and queue-to-back command paths.
    logic q_full;
    logic q_write;
    cmd_t q_wr_cmd;
    logic q_not_empty;
    logic q_read;
    cmd_t q_rd_cmd;

    // Classify incoming words and drop codes that mean nothing.
    lse_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .push_value (push_value),
        .q_full     (q_full),
        .q_write    (q_write),
        .q_cmd      (q_wr_cmd)
    );

    // Buffer commands so the two ends stall independently.
    lse_cmd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_write),
        .wr_cmd    (q_wr_cmd),
        .full      (q_full),
        .rd_en     (q_read),
        .not_empty (q_not_empty),
        .rd_cmd    (q_rd_cmd)
    );

    // Execute commands against the stack and register each result word.
    lse_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_rd_cmd),
        .cmd_pop   (q_read),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (out_value),
        .status    (status),
        .last      (last)
    );

endmodule : lifo_stack_engine_top
`default_nettype wire

FILE: verif/lifo_stack_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_engine_top_test: self-checking bench for the LIFO stack engine
// Drives operation words through the valid/stall input channel and predicts
// each result word from a local stack image. Every accepted result word is
// compared field by field against the oldest prediction. The run covers
// empty, short and full errors, dumps, swaps and ignored operation codes.
// Both sides idle and stall at random, and the load changes from phase to phase.
// ----------------------------------------------------------------------------
module lifo_stack_engine_top_test;
    import lse_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 500000;
    // Cover the slowest in-flight work: a full dump plus the command queue.
    localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 16;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // One predicted result word
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      code;
        logic                     tail;
    } stack_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          operation = OP_PUSH;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] out_value;
    logic [STATUS_W-1:0]      status;
    logic                     last;

    // Operation words waiting to be sent, and result words still owed
    cmd_t          pending_cmds[$];
    stack_result_t awaited_results[$];
    stack_result_t head_result;

    // Local stack image, updated as each word is accepted
    logic signed [DATA_W-1:0] image_entries [STACK_DEPTH];
    int                       image_count = 0;

    // Depth as the stimulus generator sees it, used to shape sequences
    int gen_depth = 0;

    int send_idle_pct  = 10;
    int recv_stall_pct = 51;
    int mismatch_count = 0;
    int cycle_count    = 0;

    lifo_stack_engine_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .push_value(push_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (out_value),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction: apply one accepted operation word to the stack image and
    // queue the result words it owes. Errors leave the image untouched.
    // ------------------------------------------------------------------------
    function automatic void emit_result(logic signed [DATA_W-1:0] value,
                                        logic [STATUS_W-1:0] code, logic tail);
        stack_result_t r;
        r.value = value;
        r.code  = code;
        r.tail  = tail;
        awaited_results.push_back(r);
    endfunction

    function automatic void apply_stack_op(logic [OP_W-1:0] op,
                                           logic signed [DATA_W-1:0] value);
        logic signed [DATA_W-1:0] held;
        case (op)
            OP_PUSH:
                if (image_count >= STACK_DEPTH)
                    emit_result('0, ST_FULL, 1'b1);
                else
                begin
                    image_entries[image_count] = value;
                    image_count++;
                end
            OP_DUMP:
                // Walk top to bottom; flag the bottom entry as the tail.
                for (int i = image_count; i > 0; i--)
                    emit_result(image_entries[i-1], ST_OK, i == 1);
            OP_PEEK:
                if (image_count == 0)
                    emit_result('0, ST_EMPTY, 1'b1);
                else
                    emit_result(image_entries[image_count-1], ST_OK, 1'b1);
            OP_POP:
                if (image_count == 0)
                    emit_result('0, ST_EMPTY, 1'b1);
                else
                    image_count--;
            OP_SWAP:
                if (image_count < 2)
                    emit_result('0, ST_SHORT, 1'b1);
                else
                begin
                    held = image_entries[image_count-1];
                    image_entries[image_count-1] = image_entries[image_count-2];
                    image_entries[image_count-2] = held;
                end
            default:
                ; // unused codes: drop silently
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
        cmd_t c;
        c.op    = op;
        c.value = value;
        pending_cmds.push_back(c);
        if (op == OP_PUSH && gen_depth < STACK_DEPTH)
            gen_depth++;
        else if (op == OP_POP && gen_depth > 0)
            gen_depth--;
    endfunction

    // Favor the extremes and small values; otherwise draw fully random bits.
    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            3:       return '1;
            4:       return int'($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    // Random mix of operations; unused codes are sprinkled in but not counted.
    task automatic queue_random_walk(int n);
        int made;
        int pick;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                queue_cmd(OP_SWAP + 3'($urandom_range(1, 3)), rand_value());
            else
            begin
                made++;
                if (pick < 46)
                    queue_cmd(OP_PUSH, rand_value());
                else if (pick < 66)
                    queue_cmd(OP_POP, rand_value());
                else if (pick < 78)
                    queue_cmd(OP_PEEK, rand_value());
                else if (pick < 90)
                    queue_cmd(OP_SWAP, rand_value());
                else
                    queue_cmd(OP_DUMP, rand_value());
            end
        end
    endtask

    // Fill to the brim, overflow, exercise the full stack, then drain to half.
    task automatic queue_fill_and_drain();
        while (gen_depth < STACK_DEPTH)
            queue_cmd(OP_PUSH, rand_value());
        queue_cmd(OP_PUSH, rand_value());
        queue_cmd(OP_PUSH, rand_value());
        queue_cmd(OP_SWAP, rand_value());
        queue_cmd(OP_PEEK, rand_value());
        queue_cmd(OP_DUMP, rand_value());
        while (gen_depth > STACK_DEPTH / 2)
            queue_cmd(OP_POP, rand_value());
    endtask

    // Hold until every word is sent and every owed result word has come back.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: predict on each accepted word, then present the next one unless
    // the channel is stalled. An idle draw lowers valid for this cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            operation  <= OP_PUSH;
            push_value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_stack_op(operation, push_value);
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid   <= 1'b1;
                    operation  <= pending_cmds[0].op;
                    push_value <= pending_cmds[0].value;
                    void'(pending_cmds.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result word against the oldest prediction,
    // then draw the stall for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                    flag_mismatch($sformatf("unexpected result word value=%0d status=%0d last=%0b",
                                            out_value, status, last));
                else
                begin
                    head_result = awaited_results.pop_front();
                    if (out_value !== head_result.value)
                        flag_mismatch($sformatf("out_value %0d, expected %0d",
                                                out_value, head_result.value));
                    if (status !== head_result.code)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                status, head_result.code));
                    if (last !== head_result.tail)
                        flag_mismatch($sformatf("last %0b, expected %0b",
                                                last, head_result.tail));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: reset, directed words, then three random phases with
    // different idle and stall loads, draining between them.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: errors on an empty stack, empty dump, short swap,
        // unused codes, extreme values, swap and a full unwind.
        queue_cmd(OP_PEEK, rand_value());
        queue_cmd(OP_POP, rand_value());
        queue_cmd(OP_SWAP, rand_value());
        queue_cmd(OP_DUMP, rand_value());
        queue_cmd(OP_PUSH, VALUE_MIN);
        queue_cmd(OP_SWAP, '1);
        queue_cmd(OP_PEEK, '0);
        for (int c = 1; c <= 3; c++)
            queue_cmd(OP_SWAP + 3'(c), rand_value());
        queue_cmd(OP_PUSH, VALUE_MAX);
        queue_cmd(OP_PUSH, '0);
        queue_cmd(OP_PUSH, '1);
        queue_cmd(OP_SWAP, rand_value());
        queue_cmd(OP_PEEK, rand_value());
        queue_cmd(OP_DUMP, rand_value());
        repeat (4) queue_cmd(OP_POP, rand_value());
        queue_cmd(OP_POP, rand_value());

        // Pause the sender until every owed word is back.
        wait_drained();

        // Phase one: light sender idling, heavy receiver stalls.
        queue_random_walk(80);
        queue_fill_and_drain();
        wait_drained();

        // Phase two: roles swapped.
        send_idle_pct  = 51;
        recv_stall_pct = 10;
        queue_random_walk(110);
        wait_drained();

        // Phase three: full throughput on both sides.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_walk(110);
        wait_drained();

        // Let any stray result word surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
